// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the canvas RTL. Every module that uses them
// has a clock named aclk and an active-low synchronous reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ACLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside of reset.
`define ACLD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// File: rtl/core/acld_pkg.sv
package acld_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int AX_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ROW_BITS = 2 * MAX_WIDTH;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 8;
    localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_MIN_W = $clog2(MAX_DIM) + 1;
    localparam int DIM_W     = (DIM_MIN_W > CFG_W) ? DIM_MIN_W : CFG_W;
    localparam int CALC_W    = DIM_W + 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;

    localparam logic [6:0] GLYPH_DOT   = 7'h2E;
    localparam logic [6:0] GLYPH_DASH  = 7'h2D;
    localparam logic [6:0] GLYPH_PIPE  = 7'h7C;
    localparam logic [6:0] GLYPH_CROSS = 7'h2B;

    typedef enum logic [1:0] {
        FUNC_HLINE = 2'd0,
        FUNC_VLINE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } acld_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_WIDTH  = 2'd0,
        REG_CANVAS_HEIGHT = 2'd1
    } acld_reg_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [5:0]              start_col;
        logic [5:0]              start_row;
        logic signed [LEN_W-1:0] line_length;
    } acld_in_t;

    typedef struct packed {
        logic       horiz_mark;
        logic       vert_mark;
        logic [6:0] glyph;
    } acld_out_t;

    // One canvas row: bit 2c is the horizontal mark of column c, bit 2c+1 the vertical.
    typedef logic [ROW_BITS-1:0] acld_row_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        acld_row_t        wr_data;
        logic             clear;
    } acld_store_req_t;

    function automatic logic [6:0] glyph_of(input logic [1:0] marks);
        logic [6:0] g;
        case (marks)
            2'b00:   g = GLYPH_DOT;
            2'b01:   g = GLYPH_DASH;
            2'b10:   g = GLYPH_PIPE;
            2'b11:   g = GLYPH_CROSS;
            default: g = GLYPH_DOT;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/acld_row_store.sv
`include "assert_macros.svh"

module acld_row_store
    import acld_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  acld_store_req_t req,
    output acld_row_t       rd_data
);

    acld_row_t              row_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0]  valid_reg;
    logic [MAX_HEIGHT-1:0]  valid_next;
    acld_row_t              rd_data_reg;
    logic                   rd_valid_reg;

    // A row that has not been written since the last clear reads as all zero.
    always_comb begin
        valid_next = valid_reg;
        if (req.clear) begin
            valid_next = '0;
        end else if (req.wr_en) begin
            valid_next[req.wr_row] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            row_mem[req.wr_row] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg  <= row_mem[req.rd_row];
            rd_valid_reg <= valid_reg[req.rd_row];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    `ACLD_ASSERT_NEVER(a_no_same_row_rw, req.rd_en && req.wr_en && (req.rd_row == req.wr_row),
        "row read and written in the same cycle")
    `ACLD_ASSERT_NEVER(a_clear_alone, req.clear && (req.wr_en || req.rd_en),
        "clear overlaps a row access")
    `ACLD_ASSERT(a_clear_drops_rows, req.clear |=> (valid_reg == '0),
        "rows still valid after clear")

endmodule

// File: rtl/core/ascii_canvas_line_drawer_unit.sv
// Line-drawing canvas of up to MAX_WIDTH x MAX_HEIGHT cells, each holding a
// horizontal and a vertical mark. The canvas is kept as one row per entry of a
// synchronous row memory; each row has a valid bit, so a clear command drops
// every row at once and no clearing pass is needed after reset. A command is
// taken only while the block is idle and yields exactly one result transaction.
// Clear and lines that mark nothing go straight to the done state; a read
// fetches one row and takes its mark, a horizontal line fetches one row, then
// the row is merged and written back whole, and a vertical line walks its rows,
// since the memory returns one row and absorbs one write-back per cycle.
// A finished result sits in an output register, so the next command is taken
// while the previous result still waits.
`include "assert_macros.svh"

module ascii_canvas_line_drawer_unit
    import acld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  acld_in_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output acld_out_t            m_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } acld_state_t;

    localparam logic signed [CALC_W-1:0] C_ZERO = '0;
    localparam logic signed [CALC_W-1:0] C_ONE  = CALC_W'(1);

    acld_state_t          state_reg, state_next;
    acld_func_t           cmd_reg, cmd_next;
    acld_row_t            mask_reg, mask_next;
    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]     next_row_reg, next_row_next;
    logic [ROW_W-1:0]     end_row_reg, end_row_next;
    logic                 last_reg, last_next;
    logic [COL_W-1:0]     rd_col_reg, rd_col_next;
    acld_out_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    acld_out_t            m_data_reg, m_data_next;
    logic [CFG_W-1:0]     canvas_width_reg, canvas_height_reg;

    acld_store_req_t      store_req;
    acld_row_t            store_rd_data;

    logic [DIM_W-1:0]     w_ext, h_ext, w_used, h_used;
    logic [DIM_W-1:0]     col_ext, row_ext, pos_ext, lim_ext;
    logic                 in_canvas, is_hline, is_vline, line_go;
    logic signed [CALC_W-1:0] pos_s, lim_s, len_s, hi_raw, lo_raw, lo_s, hi_s;
    logic [AX_W-1:0]      lo_ax, hi_ax;
    logic [ROW_W-1:0]     first_row, end_row;
    acld_row_t            line_mask;
    logic [1:0]           rd_mark;

    acld_row_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rd_data (store_rd_data)
    );

    // Sizes above the maximum act as the maximum.
    assign w_ext     = DIM_W'(canvas_width_reg);
    assign h_ext     = DIM_W'(canvas_height_reg);
    assign w_used    = (w_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_ext;
    assign h_used    = (h_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_ext;
    assign col_ext   = DIM_W'(s_data.start_col);
    assign row_ext   = DIM_W'(s_data.start_row);
    assign in_canvas = (col_ext < w_used) && (row_ext < h_used);

    assign is_hline = (s_data.func == FUNC_HLINE);
    assign is_vline = (s_data.func == FUNC_VLINE);
    assign pos_ext  = is_vline ? row_ext : col_ext;
    assign lim_ext  = is_vline ? h_used : w_used;

    assign pos_s = $signed({{(CALC_W-DIM_W){1'b0}}, pos_ext});
    assign lim_s = $signed({{(CALC_W-DIM_W){1'b0}}, lim_ext});
    assign len_s = {{(CALC_W-LEN_W){s_data.line_length[LEN_W-1]}}, s_data.line_length};

    // A positive length runs up from the start and is clipped at the far edge;
    // a negative one runs down from the start and is clipped at zero.
    assign hi_raw = pos_s + len_s - C_ONE;
    assign lo_raw = pos_s + len_s + C_ONE;
    assign hi_s   = len_s[CALC_W-1] ? pos_s
                  : ((hi_raw >= lim_s) ? (lim_s - C_ONE) : hi_raw);
    assign lo_s   = !len_s[CALC_W-1] ? pos_s
                  : ((lo_raw < C_ZERO) ? C_ZERO : lo_raw);
    assign lo_ax  = lo_s[AX_W-1:0];
    assign hi_ax  = hi_s[AX_W-1:0];

    assign line_go   = in_canvas && (len_s != C_ZERO);
    assign first_row = is_vline ? lo_ax[ROW_W-1:0] : row_ext[ROW_W-1:0];
    assign end_row   = is_vline ? hi_ax[ROW_W-1:0] : row_ext[ROW_W-1:0];

    always_comb begin
        line_mask = '0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            line_mask[2*c]   = is_hline && (AX_W'(c) >= lo_ax) && (AX_W'(c) <= hi_ax);
            line_mask[2*c+1] = is_vline && (col_ext == DIM_W'(c));
        end
    end

    assign rd_mark = store_rd_data[{rd_col_reg, 1'b0} +: 2];

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        mask_next     = mask_reg;
        cur_row_next  = cur_row_reg;
        next_row_next = next_row_reg;
        end_row_next  = end_row_reg;
        last_next     = last_reg;
        rd_col_next   = rd_col_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        store_req     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next      = acld_func_t'(s_data.func);
                    mask_next     = line_mask;
                    cur_row_next  = first_row;
                    next_row_next = first_row + 1'b1;
                    end_row_next  = end_row;
                    last_next     = (first_row == end_row);
                    rd_col_next   = col_ext[COL_W-1:0];
                    res_next      = '0;
                    state_next    = ST_DONE;
                    case (acld_func_t'(s_data.func))
                        FUNC_HLINE, FUNC_VLINE: begin
                            if (line_go) begin
                                store_req.rd_en  = 1'b1;
                                store_req.rd_row = first_row;
                                state_next       = ST_RUN;
                            end
                        end
                        FUNC_READ: begin
                            if (in_canvas) begin
                                store_req.rd_en  = 1'b1;
                                store_req.rd_row = first_row;
                                state_next       = ST_RUN;
                            end else begin
                                res_next.glyph = GLYPH_DOT;
                            end
                        end
                        FUNC_CLEAR: begin
                            store_req.clear = 1'b1;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (cmd_reg == FUNC_READ) begin
                    res_next.horiz_mark = rd_mark[0];
                    res_next.vert_mark  = rd_mark[1];
                    res_next.glyph      = glyph_of(rd_mark);
                    state_next          = ST_DONE;
                end else begin
                    store_req.wr_en   = 1'b1;
                    store_req.wr_row  = cur_row_reg;
                    store_req.wr_data = store_rd_data | mask_reg;
                    if (last_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        // The next row is fetched while the current one is written back.
                        store_req.rd_en  = 1'b1;
                        store_req.rd_row = next_row_reg;
                        cur_row_next     = next_row_reg;
                        next_row_next    = next_row_reg + 1'b1;
                        last_next        = (next_row_reg == end_row_reg);
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            canvas_width_reg  <= WIDTH_RESET;
            canvas_height_reg <= HEIGHT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && (cfg_index == REG_CANVAS_WIDTH)) begin
                canvas_width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_CANVAS_HEIGHT)) begin
                canvas_height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        mask_reg     <= mask_next;
        cur_row_reg  <= cur_row_next;
        next_row_reg <= next_row_next;
        end_row_reg  <= end_row_next;
        last_reg     <= last_next;
        rd_col_reg   <= rd_col_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ACLD_ASSERT(a_accept_leaves_idle, s_valid && s_ready |=> !s_ready,
        "block still idle after taking a transaction")
    `ACLD_ASSERT(a_run_continues,
        (state_reg == ST_RUN) && !last_reg && (cmd_reg != FUNC_READ) |=> (state_reg == ST_RUN),
        "vertical line ended before its last row")
    `ACLD_ASSERT(a_line_writes_back,
        (state_reg == ST_RUN) && (cmd_reg != FUNC_READ) |-> store_req.wr_en,
        "line row fetched but not written back")

endmodule
